// ----- hw/rtl/projection_matrix_builder_macros.svh -----
// assertion macros for the projection matrix builder
`ifndef PROJECTION_MATRIX_BUILDER_MACROS_SVH
`define PROJECTION_MATRIX_BUILDER_MACROS_SVH

// expression holds at every clock edge out of reset
`define PMB_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define PMB_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/pmb_pkg.sv -----
// shared constants and pipeline types of the projection matrix builder
package pmb_pkg;

  localparam int VALUE_WIDTH   = 32;
  localparam int FRACTION_BITS = 16;
  localparam int QW            = VALUE_WIDTH + 1;
  localparam int DW            = VALUE_WIDTH + 1;
  localparam int NW            = 2 * VALUE_WIDTH;
  localparam int NSW           = 2 * VALUE_WIDTH + 2;
  localparam int LANES         = 6;
  localparam int PAIRS         = 3;
  localparam int W_WIDTH       = 17;

  localparam logic [W_WIDTH-1:0] W_ONE = W_WIDTH'(1 << FRACTION_BITS);

  localparam logic OP_FRUSTUM = 1'b0;
  localparam logic OP_ORTHO   = 1'b1;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QW-1:0] num;
    logic [QW-1:0] quo;
    logic          neg;
    logic          ovf;
  } pmb_lane_t;

  typedef struct packed {
    logic                      valid;
    logic                      op;
    logic                      degen;
    logic [PAIRS-1:0][DW-1:0]  dvs;
    pmb_lane_t [LANES-1:0]     lane;
  } pmb_stage_t;

endpackage

// ----- hw/rtl/pmb_front.sv -----
// front pipeline: edge differences, numerators, magnitudes, overflow check
module pmb_front
  import pmb_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic                          operation,
  input  logic signed [VALUE_WIDTH-1:0] left_edge,
  input  logic signed [VALUE_WIDTH-1:0] right_edge,
  input  logic signed [VALUE_WIDTH-1:0] bottom_edge,
  input  logic signed [VALUE_WIDTH-1:0] top_edge,
  input  logic signed [VALUE_WIDTH-1:0] near_plane,
  input  logic signed [VALUE_WIDTH-1:0] far_plane,
  output pmb_stage_t                    out
);

  localparam logic signed [NSW-1:0] TWO = NSW'(1) << (2 * FRACTION_BITS + 1);

  // stage 1
  logic                          v1, op1, dg1;
  logic signed [VALUE_WIDTH:0]   d1 [PAIRS];
  logic signed [VALUE_WIDTH:0]   rsum1, tsum1, fsum1;
  logic signed [VALUE_WIDTH-1:0] n1;
  logic signed [NW-1:0]          prod1;
  // stage 2
  logic                          v2, op2, dg2;
  logic signed [VALUE_WIDTH:0]   d2 [PAIRS];
  logic signed [NSW-1:0]         num2 [LANES];
  logic signed [NSW-1:0]         num2_next [LANES];
  // stage 3
  logic                          v3, op3, dg3;
  logic [DW-1:0]                 dv3 [PAIRS];
  logic [NW-1:0]                 mag3 [LANES];
  logic                          neg3 [LANES];

  logic signed [VALUE_WIDTH:0] rl, tb, fn;
  logic signed [NSW-1:0]       two_n, rs, ts, fs, p2;
  logic [NSW-1:0]              absn [LANES];
  logic [VALUE_WIDTH:0]        absd [PAIRS];

  assign rl = (VALUE_WIDTH + 1)'(right_edge) - (VALUE_WIDTH + 1)'(left_edge);
  assign tb = (VALUE_WIDTH + 1)'(top_edge) - (VALUE_WIDTH + 1)'(bottom_edge);
  assign fn = (VALUE_WIDTH + 1)'(far_plane) - (VALUE_WIDTH + 1)'(near_plane);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    op1   <= operation;
    dg1   <= (rl == '0) || (tb == '0) || (fn == '0);
    d1[0] <= rl;
    d1[1] <= tb;
    d1[2] <= fn;
    rsum1 <= (VALUE_WIDTH + 1)'(right_edge) + (VALUE_WIDTH + 1)'(left_edge);
    tsum1 <= (VALUE_WIDTH + 1)'(top_edge) + (VALUE_WIDTH + 1)'(bottom_edge);
    fsum1 <= (VALUE_WIDTH + 1)'(far_plane) + (VALUE_WIDTH + 1)'(near_plane);
    n1    <= near_plane;
    prod1 <= NW'(far_plane) * NW'(near_plane);
  end

  assign two_n = NSW'(n1) <<< (FRACTION_BITS + 1);
  assign rs    = NSW'(rsum1) <<< FRACTION_BITS;
  assign ts    = NSW'(tsum1) <<< FRACTION_BITS;
  assign fs    = NSW'(fsum1) <<< FRACTION_BITS;
  assign p2    = NSW'(prod1) <<< 1;

  always_comb begin
    if (op1 == OP_FRUSTUM) begin
      num2_next[0] = two_n;
      num2_next[1] = rs;
      num2_next[2] = two_n;
      num2_next[3] = ts;
      num2_next[4] = -fs;
      num2_next[5] = -p2;
    end else begin
      num2_next[0] = TWO;
      num2_next[1] = -rs;
      num2_next[2] = TWO;
      num2_next[3] = -ts;
      num2_next[4] = -TWO;
      num2_next[5] = -fs;
    end
  end

  always_ff @(posedge clk) begin
    op2 <= op1;
    dg2 <= dg1;
    d2  <= d1;
    num2 <= num2_next;
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      absn[i] = num2[i][NSW-1] ? NSW'(-num2[i]) : NSW'(num2[i]);
    end
    for (int p = 0; p < PAIRS; p++) begin
      absd[p] = d2[p][VALUE_WIDTH] ? (VALUE_WIDTH + 1)'(-d2[p]) : (VALUE_WIDTH + 1)'(d2[p]);
    end
  end

  always_ff @(posedge clk) begin
    op3 <= op2;
    dg3 <= dg2;
    for (int p = 0; p < PAIRS; p++) begin
      dv3[p] <= DW'(absd[p]);
    end
    for (int i = 0; i < LANES; i++) begin
      mag3[i] <= absn[i][NW-1:0];
      neg3[i] <= num2[i][NSW-1] ^ d2[i >> 1][VALUE_WIDTH];
    end
  end

  // stage 4: flag a quotient beyond the cell count for saturation, and seed the remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else begin
      out.valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    out.op    <= op3;
    out.degen <= dg3;
    for (int p = 0; p < PAIRS; p++) begin
      out.dvs[p] <= dv3[p];
    end
    for (int i = 0; i < LANES; i++) begin
      out.lane[i].ovf <= DW'(mag3[i][NW-1:QW]) >= dv3[i >> 1];
      out.lane[i].rem <= DW'(mag3[i][NW-1:QW]);
      out.lane[i].num <= mag3[i][QW-1:0];
      out.lane[i].quo <= '0;
      out.lane[i].neg <= neg3[i];
    end
  end

endmodule

// ----- hw/rtl/pmb_cell.sv -----
// one restoring division step for all six lanes
module pmb_cell
  import pmb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  pmb_stage_t din,
  output pmb_stage_t dout
);

  logic [DW:0]   trial [LANES];
  logic          fits  [LANES];
  pmb_lane_t     lane_next [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      trial[i] = {din.lane[i].rem, din.lane[i].num[QW-1]};
      fits[i]  = trial[i] >= {1'b0, din.dvs[i >> 1]};
      lane_next[i]     = din.lane[i];
      lane_next[i].num = {din.lane[i].num[QW-2:0], 1'b0};
      lane_next[i].quo = {din.lane[i].quo[QW-2:0], fits[i]};
      lane_next[i].rem = fits[i] ? DW'(trial[i] - {1'b0, din.dvs[i >> 1]})
                                 : DW'(trial[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    dout.op    <= din.op;
    dout.degen <= din.degen;
    dout.dvs   <= din.dvs;
    for (int i = 0; i < LANES; i++) begin
      dout.lane[i] <= lane_next[i];
    end
  end

endmodule

// ----- hw/rtl/pmb_back.sv -----
// saturation and matrix entry assembly
module pmb_back
  import pmb_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  pmb_stage_t                    din,
  output logic                          done,
  output logic signed [VALUE_WIDTH-1:0] x_scale,
  output logic signed [VALUE_WIDTH-1:0] y_scale,
  output logic signed [VALUE_WIDTH-1:0] x_skew,
  output logic signed [VALUE_WIDTH-1:0] y_skew,
  output logic signed [VALUE_WIDTH-1:0] depth_scale,
  output logic signed [W_WIDTH-1:0]     w_from_z,
  output logic signed [VALUE_WIDTH-1:0] x_offset,
  output logic signed [VALUE_WIDTH-1:0] y_offset,
  output logic signed [VALUE_WIDTH-1:0] depth_offset,
  output logic [W_WIDTH-1:0]            w_constant,
  output logic                          degenerate
);

  localparam logic [VALUE_WIDTH-1:0] SMAX = {1'b0, {(VALUE_WIDTH - 1){1'b1}}};
  localparam logic [VALUE_WIDTH-1:0] SMIN = {1'b1, {(VALUE_WIDTH - 1){1'b0}}};

  logic [VALUE_WIDTH-1:0] sat [LANES];
  logic [QW-1:0]          negq [LANES];
  logic                   pos_big, neg_big;
  logic                   fr;
  logic                   dz;

  always_comb begin
    pos_big = 1'b0;
    neg_big = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      negq[i] = QW'(0) - din.lane[i].quo;
      pos_big = din.lane[i].ovf || (din.lane[i].quo[QW-1:VALUE_WIDTH-1] != '0);
      neg_big = din.lane[i].ovf || din.lane[i].quo[QW-1] ||
                (din.lane[i].quo[VALUE_WIDTH-1] && (din.lane[i].quo[VALUE_WIDTH-2:0] != '0));
      if (din.lane[i].neg) begin
        sat[i] = neg_big ? SMIN : negq[i][VALUE_WIDTH-1:0];
      end else begin
        sat[i] = pos_big ? SMAX : din.lane[i].quo[VALUE_WIDTH-1:0];
      end
    end
  end

  assign fr = (din.op == OP_FRUSTUM);
  assign dz = din.degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    degenerate   <= dz;
    x_scale      <= dz ? '0 : sat[0];
    y_scale      <= dz ? '0 : sat[2];
    x_skew       <= (dz || !fr) ? '0 : sat[1];
    y_skew       <= (dz || !fr) ? '0 : sat[3];
    x_offset     <= (dz || fr) ? '0 : sat[1];
    y_offset     <= (dz || fr) ? '0 : sat[3];
    depth_scale  <= dz ? '0 : sat[4];
    depth_offset <= dz ? '0 : sat[5];
    w_from_z     <= (dz || !fr) ? '0 : W_ONE;
    w_constant   <= (dz || fr) ? '0 : W_ONE;
  end

endmodule

// ----- hw/rtl/projection_matrix_builder.sv -----
// top level: projection matrix builder, front pipeline, divider cell chain, output stage
// pipeline from start to done: 4 front stages, 33 divider cells, 1 output stage
// throughput: one view volume per cycle; busy is always low
// the chain of 33 cells, one quotient bit each, sets the latency
// reset clears every valid flag at once; data registers are not reset
// done pulses for one cycle per accepted view volume, in order of acceptance
module projection_matrix_builder
  import pmb_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation,
  input  logic signed [VALUE_WIDTH-1:0] left_edge,
  input  logic signed [VALUE_WIDTH-1:0] right_edge,
  input  logic signed [VALUE_WIDTH-1:0] bottom_edge,
  input  logic signed [VALUE_WIDTH-1:0] top_edge,
  input  logic signed [VALUE_WIDTH-1:0] near_plane,
  input  logic signed [VALUE_WIDTH-1:0] far_plane,
  output logic                          done,
  output logic signed [VALUE_WIDTH-1:0] x_scale,
  output logic signed [VALUE_WIDTH-1:0] y_scale,
  output logic signed [VALUE_WIDTH-1:0] x_skew,
  output logic signed [VALUE_WIDTH-1:0] y_skew,
  output logic signed [VALUE_WIDTH-1:0] depth_scale,
  output logic signed [W_WIDTH-1:0]     w_from_z,
  output logic signed [VALUE_WIDTH-1:0] x_offset,
  output logic signed [VALUE_WIDTH-1:0] y_offset,
  output logic signed [VALUE_WIDTH-1:0] depth_offset,
  output logic [W_WIDTH-1:0]            w_constant,
  output logic                          degenerate
);

  // stage bundles between the cells; entry 0 comes out of the front end
  pmb_stage_t chain [QW+1];

  // fully pipelined, so a transfer is taken every cycle
  assign busy = 1'b0;

  // differences, numerators per lane, magnitudes and the overflow check
  pmb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (start && !busy),
    .operation   (operation),
    .left_edge   (left_edge),
    .right_edge  (right_edge),
    .bottom_edge (bottom_edge),
    .top_edge    (top_edge),
    .near_plane  (near_plane),
    .far_plane   (far_plane),
    .out         (chain[0])
  );

  // each cell brings down one numerator bit and makes one quotient bit
  for (genvar k = 0; k < QW; k++) begin : g_cell
    pmb_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (chain[k]),
      .dout (chain[k+1])
    );
  end

  // sign, saturation and placement into the matrix entries
  pmb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .din          (chain[QW]),
    .done         (done),
    .x_scale      (x_scale),
    .y_scale      (y_scale),
    .x_skew       (x_skew),
    .y_skew       (y_skew),
    .depth_scale  (depth_scale),
    .w_from_z     (w_from_z),
    .x_offset     (x_offset),
    .y_offset     (y_offset),
    .depth_offset (depth_offset),
    .w_constant   (w_constant),
    .degenerate   (degenerate)
  );

endmodule

// ----- hw/rtl/pmb_checker.sv -----
// port-level checks of the projection matrix builder, bound to the top level
`include "projection_matrix_builder_macros.svh"

module pmb_checker
  import pmb_pkg::*;
(
  input logic                          clk,
  input logic                          rst,
  input logic                          busy,
  input logic                          done,
  input logic signed [VALUE_WIDTH-1:0] x_scale,
  input logic signed [VALUE_WIDTH-1:0] x_skew,
  input logic signed [VALUE_WIDTH-1:0] y_skew,
  input logic signed [VALUE_WIDTH-1:0] depth_offset,
  input logic signed [W_WIDTH-1:0]     w_from_z,
  input logic [W_WIDTH-1:0]            w_constant,
  input logic                          degenerate
);

  `PMB_ASSERT_ALWAYS(a_never_busy, clk, rst, !busy)
  `PMB_ASSERT_IMPL(a_degen_zero, clk, rst, done && degenerate, (x_scale == 0) && (depth_offset == 0) && (w_from_z == 0) && (w_constant == 0))
  `PMB_ASSERT_IMPL(a_one_w, clk, rst, done && !degenerate, (w_from_z == 0) != (w_constant == 0))
  `PMB_ASSERT_IMPL(a_ortho_no_skew, clk, rst, done && (w_constant != 0), (x_skew == 0) && (y_skew == 0))

endmodule

bind projection_matrix_builder pmb_checker u_pmb_checker (.*);
